// ===== hw/rtl/idl_pkg.sv =====
// ----------------------------------------------------------------------------
// idl_pkg: shared types and constants of the identifier/number lexer
// Token class codes, byte codes, the per-byte result bundle and helpers.
// ----------------------------------------------------------------------------
package idl_pkg;

	localparam int POS_BITS_DEF = 16;
	localparam int FIELD_W      = 16;
	localparam int SAT_W        = 33;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	// token classes
	localparam logic [3:0] CLS_IDENT  = 4'd0;
	localparam logic [3:0] CLS_NUMBER = 4'd1;
	localparam logic [3:0] CLS_LBRACE = 4'd2;
	localparam logic [3:0] CLS_RBRACE = 4'd3;
	localparam logic [3:0] CLS_LPAREN = 4'd4;
	localparam logic [3:0] CLS_RPAREN = 4'd5;
	localparam logic [3:0] CLS_LBRACK = 4'd6;
	localparam logic [3:0] CLS_RBRACK = 4'd7;
	localparam logic [3:0] CLS_ERROR  = 4'd8;
	localparam logic [3:0] CLS_END    = 4'd9;

	// byte codes
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_DIGIT_0 = 8'd48;
	localparam logic [7:0] CH_DIGIT_9 = 8'd57;
	localparam logic [7:0] CH_UNDER   = 8'd95;
	localparam logic [7:0] CH_LBRACE  = 8'd123;
	localparam logic [7:0] CH_RBRACE  = 8'd125;
	localparam logic [7:0] CH_LPAREN  = 8'd40;
	localparam logic [7:0] CH_RPAREN  = 8'd41;
	localparam logic [7:0] CH_LBRACK  = 8'd91;
	localparam logic [7:0] CH_RBRACK  = 8'd93;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	// Up to three results per byte: a closed token, a middle item
	// (delimiter, error or one-byte token at the final byte) and the end item.
	typedef struct packed {
		logic               tok_v;
		logic               tok_num;
		logic [FIELD_W-1:0] tok_start;
		logic [FIELD_W-1:0] tok_len;
		logic               mid_v;
		logic [3:0]         mid_cls;
		logic               mid_len1;
		logic               end_v;
		logic [FIELD_W-1:0] pos;
	} bundle_t;

	function automatic logic is_alpha(logic [7:0] c);
		return c inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z]};
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c inside {[CH_DIGIT_0:CH_DIGIT_9]};
	endfunction

	// delimiter class, or CLS_IDENT when the byte is no delimiter
	function automatic logic [3:0] delim_class(logic [7:0] c);
		logic [3:0] r;
		case (c)
			CH_LBRACE: r = CLS_LBRACE;
			CH_RBRACE: r = CLS_RBRACE;
			CH_LPAREN: r = CLS_LPAREN;
			CH_RPAREN: r = CLS_RPAREN;
			CH_LBRACK: r = CLS_LBRACK;
			CH_RBRACK: r = CLS_RBRACK;
			default:   r = CLS_IDENT;
		endcase
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] sat_field(logic [SAT_W-1:0] v);
		return (v > SAT_W'(FIELD_MAX)) ? FIELD_MAX : v[FIELD_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/idl_in_if.sv =====
// ----------------------------------------------------------------------------
// idl_in_if: byte channel
// Carries one source byte and its end-of-string mark per transaction.
// ----------------------------------------------------------------------------
interface idl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink (input valid, char_code, last_char, output ready);
endinterface

// ===== hw/rtl/idl_out_if.sv =====
// ----------------------------------------------------------------------------
// idl_out_if: token descriptor channel
// Carries one token descriptor per transaction.
// ----------------------------------------------------------------------------
interface idl_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_class;
	logic [15:0] start_position;
	logic [15:0] token_length;
	logic        run_last;

	modport source (output valid, token_class, start_position, token_length, run_last,
		input ready);
	modport sink (input valid, token_class, start_position, token_length, run_last,
		output ready);
endinterface

// ===== hw/rtl/idl_front.sv =====
// ----------------------------------------------------------------------------
// idl_front: byte classifier and scan state
// Accepts one byte per cycle while the queue is not full and builds the bundle of results it causes.
// ----------------------------------------------------------------------------
module idl_front import idl_pkg::*; #(
	parameter int POSITION_BITS = POS_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	idl_in_if.sink   char_in,
	output logic     push,
	output bundle_t  push_data,
	input  logic     full
);

	typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_SKIP} mode_t;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	mode_t                    mode_q, mode_mid, mode_nxt;
	logic [POSITION_BITS-1:0] pos_q, pos_nxt;
	logic [POSITION_BITS-1:0] start_q, start_nxt;
	logic [POSITION_BITS-1:0] ts, close_len;
	logic [POSITION_BITS:0]   flush_len;
	logic [7:0]               c;
	logic                     alpha, digit, sep, keeps, started, accept;
	logic [3:0]               dcls;
	bundle_t                  b;

	assign c       = char_in.char_code;
	assign alpha   = is_alpha(c);
	assign digit   = is_digit(c);
	assign sep     = c inside {CH_SPACE, CH_NEWLINE};
	assign dcls    = delim_class(c);
	assign ts      = (start_q <= pos_q) ? start_q : pos_q;
	assign close_len = pos_q - ts;
	assign flush_len = {1'b0, pos_q} + (POSITION_BITS+1)'(1) - {1'b0, ts};

	assign char_in.ready = !full;
	assign accept        = char_in.valid && !full;
	assign push          = accept && (b.tok_v || b.mid_v || b.end_v);
	assign push_data     = b;

	always_comb begin
		case (mode_q)
			MODE_IDENT:  keeps = alpha || digit || (c == CH_UNDER);
			MODE_NUMBER: keeps = digit;
			default:     keeps = 1'b0;
		endcase

		b         = '0;
		b.pos     = sat_field(SAT_W'(pos_q));
		mode_mid  = mode_q;
		start_nxt = start_q;
		started   = 1'b0;

		if (mode_q != MODE_SKIP && !keeps) begin
			// close the pending token
			if (mode_q inside {MODE_IDENT, MODE_NUMBER}) begin
				b.tok_v     = 1'b1;
				b.tok_num   = (mode_q == MODE_NUMBER);
				b.tok_start = sat_field(SAT_W'(ts));
				b.tok_len   = sat_field(SAT_W'(close_len));
				mode_mid    = MODE_IDLE;
			end
			if (sep) begin
				// separator only
			end else if (alpha) begin
				mode_mid  = MODE_IDENT;
				start_nxt = pos_q;
				started   = 1'b1;
			end else if (digit) begin
				mode_mid  = MODE_NUMBER;
				start_nxt = pos_q;
				started   = 1'b1;
			end else if (dcls != CLS_IDENT) begin
				b.mid_v    = 1'b1;
				b.mid_cls  = dcls;
				b.mid_len1 = 1'b1;
			end else begin
				b.mid_v    = 1'b1;
				b.mid_cls  = CLS_ERROR;
				b.mid_len1 = 1'b0;
				mode_mid   = MODE_SKIP;
			end
		end

		mode_nxt = mode_mid;
		pos_nxt  = (pos_q == POS_MAX) ? pos_q : pos_q + POSITION_BITS'(1);

		if (char_in.last_char) begin
			// flush the open token, then close the string
			if (mode_mid inside {MODE_IDENT, MODE_NUMBER}) begin
				if (started) begin
					b.mid_v    = 1'b1;
					b.mid_cls  = (mode_mid == MODE_NUMBER) ? CLS_NUMBER : CLS_IDENT;
					b.mid_len1 = 1'b1;
				end else begin
					b.tok_v     = 1'b1;
					b.tok_num   = (mode_mid == MODE_NUMBER);
					b.tok_start = sat_field(SAT_W'(ts));
					b.tok_len   = sat_field(SAT_W'(flush_len));
				end
			end
			b.end_v   = 1'b1;
			mode_nxt  = MODE_IDLE;
			pos_nxt   = '0;
			start_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_nxt;
			pos_q   <= pos_nxt;
			start_q <= start_nxt;
		end
	end

endmodule

// ===== hw/rtl/idl_queue.sv =====
// ----------------------------------------------------------------------------
// idl_queue: bundle queue
// Short register queue between classifier and emitter; head is visible.
// ----------------------------------------------------------------------------
module idl_queue import idl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    full,
	output logic    head_v,
	output bundle_t head,
	input  logic    pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	bundle_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign head_v  = (cnt_q != '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && head_v;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/idl_back.sv =====
// ----------------------------------------------------------------------------
// idl_back: descriptor emitter
// Sends the items of the head bundle one per cycle, while token_out is not stalled, through an output register.
// ----------------------------------------------------------------------------
module idl_back import idl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_v,
	input  bundle_t   head,
	output logic      pop,
	idl_out_if.source token_out
);

	logic [2:0]         sent_q, pend, sel;
	logic               advance, last_item;
	logic               out_valid_q;
	logic [3:0]         cls_q, cls_d;
	logic [FIELD_W-1:0] start_q, start_d, len_q, len_d;
	logic               run_last_q;

	assign pend      = {head.end_v, head.mid_v, head.tok_v} & ~sent_q;
	assign sel       = pend & (~pend + 3'd1);
	assign last_item = ((pend & ~sel) == 3'b000);
	assign advance   = head_v && (pend != 3'b000) && (!out_valid_q || token_out.ready);
	assign pop       = advance && last_item;

	always_comb begin
		cls_d   = CLS_END;
		start_d = head.pos;
		len_d   = '0;
		if (sel[0]) begin
			cls_d   = head.tok_num ? CLS_NUMBER : CLS_IDENT;
			start_d = head.tok_start;
			len_d   = head.tok_len;
		end else if (sel[1]) begin
			cls_d = head.mid_cls;
			len_d = FIELD_W'(head.mid_len1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				sent_q <= last_item ? 3'b000 : (sent_q | sel);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (token_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_q      <= cls_d;
			start_q    <= start_d;
			len_q      <= len_d;
			run_last_q <= last_item;
		end
	end

	assign token_out.valid          = out_valid_q;
	assign token_out.token_class    = cls_q;
	assign token_out.start_position = start_q;
	assign token_out.token_length   = len_q;
	assign token_out.run_last       = run_last_q;

endmodule

// ===== hw/rtl/identifier_number_delimiter_lexer.sv =====
// ----------------------------------------------------------------------------
// identifier_number_delimiter_lexer: streaming identifier/number lexer
// Turns a byte stream into token descriptors (class, start, length).
// ----------------------------------------------------------------------------
//
//  channel    | dir | transaction                      | fields
//  -----------+-----+----------------------------------+-----------------------
//  char_in    | in  | one source byte                  | char_code, last_char
//  token_out  | out | one token, error or end item     | token_class,
//             |     |                                  | start_position,
//             |     |                                  | token_length, run_last
//
//  A byte is taken every cycle while the bundle queue has room; the classifier
//  decides all results of a byte in the cycle it is taken. Results leave at one
//  per cycle from the output register while token_out is not stalled; a byte
//  causes 0 to 3 results, and the output port sets the sustained rate.
//  Reset (arst_n low) clears scan mode, position, queue and output valid.
//  A stall on token_out fills the queue; char_in.ready drops only when the
//  queue is full, and no byte or result is lost.
//
module identifier_number_delimiter_lexer import idl_pkg::*; #(
	// byte position counter width, 8 to 32
	parameter int POSITION_BITS = POS_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	idl_in_if.sink    char_in,
	idl_out_if.source token_out
);

	// front to queue
	logic    push, full;
	bundle_t push_data;

	// queue to back
	logic    head_v, pop;
	bundle_t head;

	// classify each byte, track scan mode and positions
	idl_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// hold result bundles so each side can stall on its own
	idl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.head_v    (head_v),
		.head      (head),
		.pop       (pop)
	);

	// serialize bundle items onto the output channel
	idl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_v    (head_v),
		.head      (head),
		.pop       (pop),
		.token_out (token_out)
	);

endmodule

// ===== sim/identifier_number_delimiter_lexer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identifier_number_delimiter_lexer_test: self-checking lexer testbench
// Streams strings of bytes into the lexer and checks every token descriptor.
// It uses directed strings, random well-formed and broken phrases and random
// noise. A behavioral scanner predicts each descriptor when its byte is
// accepted. Both channels idle at random.
// ----------------------------------------------------------------------------
module identifier_number_delimiter_lexer_test import idl_pkg::*;;

	localparam int          POSITION_BITS = POS_BITS_DEF;
	localparam logic [32:0] POS_MAX       = (33'd1 << POSITION_BITS) - 33'd1;
	localparam int          STALL_LIMIT   = 2000;
	localparam int          DRAIN_CYCLES  = 16;
	localparam int          RANDOM_BYTES  = 320;

	// scanner state of the predictor
	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_IDENT,
		SCAN_NUMBER,
		SCAN_SKIP
	} scan_mode_t;

	// one byte waiting to be sent, with its idle gap and pacing flags
	typedef struct {
		logic [7:0] code;
		logic       last;
		int         gap;
		bit         hold;
		bit         calm;
	} byte_item_t;

	// one token descriptor as the block should emit it
	typedef struct {
		logic [3:0]  cls;
		logic [15:0] start;
		logic [15:0] len;
		logic        run_last;
	} descr_t;

	logic clk;
	logic arst_n;

	idl_in_if  char_in ();
	idl_out_if token_out ();

	identifier_number_delimiter_lexer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.token_out (token_out)
	);

	// stimulus waiting for the driver, descriptors waiting for the monitor
	byte_item_t pending_bytes[$];
	descr_t     expected_tokens[$];
	logic [7:0] text_buf[$];

	// predictor state
	scan_mode_t  scan_mode_q;
	logic [32:0] byte_pos_q;
	logic [32:0] token_start_q;

	// pacing controls used by the stimulus builder
	bit calm;
	bit hold_next;

	// driver and monitor bookkeeping
	byte_item_t next_byte;
	descr_t     want;
	logic       byte_taken;
	logic       result_taken;
	bit         calm_now;
	int         gap_count;
	int         sink_wait;
	int         idle_cycles;

	// run statistics
	int failures;
	int strings_sent;
	int bytes_sent;
	int tokens_checked;
	int random_bytes;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic logic letter(logic [7:0] c);
		return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
	endfunction

	function automatic logic numeral(logic [7:0] c);
		return c inside {[CH_DIGIT_0:CH_DIGIT_9]};
	endfunction

	// bracket token class; CLS_ERROR for anything that is not a bracket
	function automatic logic [3:0] bracket_class(logic [7:0] c);
		case (c)
			CH_LBRACE: return CLS_LBRACE;
			CH_RBRACE: return CLS_RBRACE;
			CH_LPAREN: return CLS_LPAREN;
			CH_RPAREN: return CLS_RPAREN;
			CH_LBRACK: return CLS_LBRACK;
			CH_RBRACK: return CLS_RBRACK;
			default:   return CLS_ERROR;
		endcase
	endfunction

	function automatic logic [15:0] clip16(logic [32:0] v);
		return (v > 33'(FIELD_MAX)) ? FIELD_MAX : v[15:0];
	endfunction

	function automatic descr_t make_descr(logic [3:0] cls, logic [32:0] start, logic [32:0] len);
		descr_t d;
		d.cls      = cls;
		d.start    = clip16(start);
		d.len      = clip16(len);
		d.run_last = 1'b0;
		return d;
	endfunction

	// Advance the scanner by one accepted byte and queue the descriptors it causes.
	task automatic lex_byte(input logic [7:0] c, input logic fin);
		descr_t      burst[$];
		logic [32:0] p;
		logic [32:0] ts;
		logic        keeps;
		p     = byte_pos_q;
		keeps = 1'b0;
		if (scan_mode_q != SCAN_SKIP) begin
			if (scan_mode_q == SCAN_IDENT)
				keeps = letter(c) || numeral(c) || c == CH_UNDER;
			else if (scan_mode_q == SCAN_NUMBER)
				keeps = numeral(c);
			if (!keeps) begin
				// close the pending token; its length excludes this byte
				if (scan_mode_q inside {SCAN_IDENT, SCAN_NUMBER}) begin
					ts = (token_start_q <= p) ? token_start_q : p;
					burst.insert(burst.size(), make_descr(
						scan_mode_q == SCAN_IDENT ? CLS_IDENT : CLS_NUMBER, ts, p - ts));
					scan_mode_q = SCAN_IDLE;
				end
				if (!(c inside {CH_SPACE, CH_NEWLINE})) begin
					if (letter(c)) begin
						scan_mode_q   = SCAN_IDENT;
						token_start_q = p;
					end else if (numeral(c)) begin
						scan_mode_q   = SCAN_NUMBER;
						token_start_q = p;
					end else if (bracket_class(c) != CLS_ERROR) begin
						burst.insert(burst.size(), make_descr(bracket_class(c), p, 33'd1));
					end else begin
						// unknown byte: report it and skip to the end of the string
						burst.insert(burst.size(), make_descr(CLS_ERROR, p, 33'd0));
						scan_mode_q = SCAN_SKIP;
					end
				end
			end
		end
		if (fin) begin
			// final byte: flush the open token, it includes this byte
			if (scan_mode_q inside {SCAN_IDENT, SCAN_NUMBER}) begin
				ts = (token_start_q <= p) ? token_start_q : p;
				burst.insert(burst.size(), make_descr(
					scan_mode_q == SCAN_IDENT ? CLS_IDENT : CLS_NUMBER, ts, p + 33'd1 - ts));
			end
			burst.insert(burst.size(), make_descr(CLS_END, p, 33'd0));
			scan_mode_q   = SCAN_IDLE;
			byte_pos_q    = '0;
			token_start_q = '0;
		end else begin
			byte_pos_q = (p == POS_MAX) ? p : p + 33'd1;
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].run_last = 1'b1;
		foreach (burst[i])
			expected_tokens.insert(expected_tokens.size(), burst[i]);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------------
	// Move the text buffer to the driver queue as one string.
	task automatic queue_text();
		byte_item_t b;
		foreach (text_buf[i]) begin
			b.code = text_buf[i];
			b.last = (i == text_buf.size() - 1);
			b.gap  = calm ? 0 : int'($urandom_range(0, 15));
			b.hold = hold_next && (i == 0);
			b.calm = calm;
			pending_bytes.insert(pending_bytes.size(), b);
		end
		text_buf.delete();
		strings_sent++;
	endtask

	task automatic say(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.insert(text_buf.size(), s[i]);
		queue_text();
	endtask

	function automatic logic [7:0] any_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? CH_UPPER_A + 8'(r) : CH_LOWER_A + 8'(r - 26);
	endfunction

	function automatic logic [7:0] any_digit();
		return CH_DIGIT_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Fill the text buffer with a random sequence of valid tokens and separators.
	task automatic build_phrase();
		logic [7:0] brackets[6];
		int         pieces;
		brackets = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK};
		pieces   = $urandom_range(1, 6);
		repeat (pieces) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					text_buf.insert(text_buf.size(), any_letter());
					repeat ($urandom_range(0, 5)) begin
						case ($urandom_range(0, 2))
							0:       text_buf.insert(text_buf.size(), any_letter());
							1:       text_buf.insert(text_buf.size(), any_digit());
							default: text_buf.insert(text_buf.size(), CH_UNDER);
						endcase
					end
				end
				4, 5: begin
					repeat ($urandom_range(1, 5))
						text_buf.insert(text_buf.size(), any_digit());
				end
				6, 7: text_buf.insert(text_buf.size(), brackets[$urandom_range(0, 5)]);
				default: text_buf.insert(text_buf.size(),
					$urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
			endcase
		end
	endtask

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Driver: present one byte transaction at a time from the pending queue.
	// Inputs change on the falling edge only.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!char_in.valid || byte_taken) begin
				// free to present the next byte once its gap has passed; a held
				// byte also waits until every expected descriptor has arrived
				if (pending_bytes.size() > 0 && gap_count >= pending_bytes[0].gap &&
					!(pending_bytes[0].hold && expected_tokens.size() > 0)) begin
					next_byte          = pending_bytes.pop_front();
					char_in.valid     <= 1'b1;
					char_in.char_code <= next_byte.code;
					char_in.last_char <= next_byte.last;
					calm_now          <= next_byte.calm;
					gap_count          = 0;
				end else begin
					char_in.valid <= 1'b0;
					if (pending_bytes.size() > 0 && gap_count < pending_bytes[0].gap)
						gap_count++;
				end
			end
		end
	end

	// Sink side: after each accepted descriptor, stall for a random number of cycles, or not at all in calm strings.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken)
				sink_wait = calm_now ? 0 : int'($urandom_range(0, 15));
			if (sink_wait > 0) begin
				sink_wait--;
				token_out.ready <= 1'b0;
			end else begin
				token_out.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: sample both channels on the rising edge, predict on accepted
	// bytes, check accepted descriptors against the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_taken   <= 1'b0;
			result_taken <= 1'b0;
		end else begin
			byte_taken   <= char_in.valid && char_in.ready;
			result_taken <= token_out.valid && token_out.ready;

			if (char_in.valid && char_in.ready) begin
				bytes_sent++;
				lex_byte(char_in.char_code, char_in.last_char);
			end

			if (token_out.valid && token_out.ready) begin
				tokens_checked++;
				if (expected_tokens.size() == 0) begin
					$error("unexpected descriptor: token_class %0d start_position %0d",
						token_out.token_class, token_out.start_position);
					failures++;
				end else begin
					want = expected_tokens.pop_front();
					if (token_out.token_class !== want.cls) begin
						$error("token_class: expected %0d, got %0d", want.cls,
							token_out.token_class);
						failures++;
					end
					if (token_out.start_position !== want.start) begin
						$error("start_position: expected %0d, got %0d", want.start,
							token_out.start_position);
						failures++;
					end
					if (token_out.token_length !== want.len) begin
						$error("token_length: expected %0d, got %0d", want.len,
							token_out.token_length);
						failures++;
					end
					if (token_out.run_last !== want.run_last) begin
						$error("run_last: expected %0d, got %0d", want.run_last,
							token_out.run_last);
						failures++;
					end
				end
			end

			// watchdog: count cycles with no transaction on either channel
			if ((char_in.valid && char_in.ready) || (token_out.valid && token_out.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n              = 1'b0;
		char_in.valid       = 1'b0;
		char_in.char_code   = '0;
		char_in.last_char   = 1'b0;
		token_out.ready     = 1'b0;
		scan_mode_q         = SCAN_IDLE;
		byte_pos_q          = '0;
		token_start_q       = '0;
		calm                = 1'b0;
		hold_next           = 1'b0;
		gap_count           = 0;
		sink_wait           = 0;
		idle_cycles         = 0;
		failures            = 0;
		strings_sent        = 0;
		bytes_sent          = 0;
		tokens_checked      = 0;
		random_bytes        = 0;

		// Directed strings: single-byte identifier, identifier with digits and
		// underscore, every bracket, a lone separator, error then ignored bytes,
		// high and zero bytes, a byte that causes three descriptors (sent only
		// after everything before it has drained), and a number running
		// straight into an identifier.
		say("A");
		say("z9_ 0");
		say("{}()[]");
		say("\n");
		say("x#q");
		text_buf.insert(text_buf.size(), 8'hFF);
		queue_text();
		hold_next = 1'b1;
		say("12(");
		hold_next = 1'b0;
		say("9a");
		text_buf.insert(text_buf.size(), 8'h00);
		text_buf.insert(text_buf.size(), 8'h80);
		text_buf.insert(text_buf.size(), CH_DIGIT_9);
		queue_text();

		// Random part: mostly well-formed phrases, some with one byte broken,
		// and some pure noise. Occasional strings run with no idling, and some
		// wait until all expected descriptors have drained.
		while (random_bytes < RANDOM_BYTES) begin
			calm      = ($urandom_range(0, 3) == 0);
			hold_next = ($urandom_range(0, 9) == 0);
			case ($urandom_range(0, 9))
				7: begin
					build_phrase();
					text_buf[$urandom_range(0, text_buf.size() - 1)] = any_byte();
				end
				8, 9: begin
					repeat ($urandom_range(1, 8))
						text_buf.insert(text_buf.size(), any_byte());
				end
				default: begin
					build_phrase();
				end
			endcase
			random_bytes += text_buf.size();
			queue_text();
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: wait for all bytes and descriptors, then let the pipeline settle
		while (pending_bytes.size() > 0 || expected_tokens.size() > 0 || char_in.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_tokens.size() > 0) begin
			$error("%0d expected descriptors never arrived", expected_tokens.size());
			failures++;
		end
		$display("Covered %0d strings, %0d bytes and %0d descriptors, including", strings_sent,
			bytes_sent, tokens_checked);
		$display("every bracket, error skipping, high bytes and random stalls on both sides.");
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
